>>> hdl/vec3_normalize_unit_assert.svh
// ----------------------------------------------------------------------------
// vec3_normalize_unit_assert.svh
// Assertion macros used by the vector normalization checker.
// ----------------------------------------------------------------------------
`ifndef VEC3_NORMALIZE_UNIT_ASSERT_SVH
`define VEC3_NORMALIZE_UNIT_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent.
`define V3N_CHECK_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check a consequent in the cycle after its antecedent.
`define V3N_CHECK_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hdl/v3n_pkg.sv
// ----------------------------------------------------------------------------
// v3n_pkg
// Widths, step types and per-step functions of the vector normalization pipe.
// ----------------------------------------------------------------------------
package v3n_pkg;

    localparam int COMP_BITS = 16;
    localparam int FRAC_BITS = 14;
    localparam int UNIT_BITS = FRAC_BITS + 2;
    localparam int N_BITS    = FRAC_BITS + 1;
    localparam int SUM_W     = 2 * COMP_BITS;
    localparam int REM_W     = COMP_BITS + 3;
    localparam int TS_W      = FRAC_BITS + 2 * COMP_BITS + 3;
    localparam int E_W       = 2 * FRAC_BITS + 2 * COMP_BITS + 5;
    localparam int NSTEPS    = (COMP_BITS > N_BITS) ? COMP_BITS : N_BITS;

    typedef logic        [COMP_BITS-1:0] mag_t;
    typedef logic        [SUM_W-1:0]     sum_t;
    typedef logic        [REM_W-1:0]     rem_t;
    typedef logic        [COMP_BITS-1:0] root_t;
    typedef logic signed [TS_W-1:0]      prod_t;
    typedef logic signed [E_W-1:0]       err_t;
    typedef logic        [N_BITS-1:0]    quot_t;

    typedef struct packed {
        rem_t  rem;
        root_t root;
    } sq_step_t;

    typedef struct packed {
        err_t  e;
        prod_t ts;
        logic  hit;
    } u_step_t;

    // One digit of the restoring square root.
    function automatic sq_step_t sqrt_step(rem_t rem, root_t root, logic [1:0] pair);
        rem_t     t;
        rem_t     trial;
        sq_step_t r;
        t     = {rem[COMP_BITS:0], pair};
        trial = {1'b0, root, 2'b01};
        if (t >= trial)
        begin
            r.rem  = t - trial;
            r.root = {root[COMP_BITS-2:0], 1'b1};
        end
        else
        begin
            r.rem  = t;
            r.root = {root[COMP_BITS-2:0], 1'b0};
        end
        return r;
    endfunction

    // Try to set quotient bit k: E tracks 4*m^2*4^F - T^2*S, TS tracks T*S, T = 2n-1.
    function automatic u_step_t unit_step(err_t e, prod_t ts, sum_t s, int k);
        err_t    ts_x;
        err_t    s_x;
        err_t    cand;
        prod_t   s_p;
        u_step_t r;
        ts_x  = $signed({{(E_W-TS_W){ts[TS_W-1]}}, ts});
        s_x   = $signed({{(E_W-SUM_W){1'b0}}, s});
        s_p   = $signed({{(TS_W-SUM_W){1'b0}}, s});
        cand  = e - (ts_x <<< (k + 2)) - (s_x <<< (2 * k + 2));
        r.hit = ~cand[E_W-1];
        r.e   = r.hit ? cand : e;
        r.ts  = r.hit ? (ts + (s_p <<< (k + 1))) : ts;
        return r;
    endfunction

endpackage

>>> hdl/vec3_normalize_unit.sv
// ----------------------------------------------------------------------------
// vec3_normalize_unit
// Length and Q1.14 unit vector of a signed 3-component vector.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries comp_x, comp_y, comp_z (signed).
//   Output channel out_valid/out_ready carries unit_x/y/z (signed Q1.14),
//   vec_length = floor(sqrt(x^2+y^2+z^2)) and zero_vector.
//   A request passes 20 registers: magnitude, square, sum, 16 digit
//   steps (one square root digit per step, one quotient bit for all three
//   components in each of the first 15 steps) and an output register.
//   Throughput is one request per cycle while the receiver does not stall;
//   the 16 root digits set the depth.
//   A zero vector yields zero components and length with zero_vector high.
//   Reset clears every stage valid bit; payload registers are not reset.
//   When the receiver stalls, the whole pipe holds and in_ready drops;
//   nothing is lost or repeated. in_ready stays high while the output
//   register is empty or being drained.
// ----------------------------------------------------------------------------
module vec3_normalize_unit
    import v3n_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [COMP_BITS-1:0] comp_x,
    input  logic signed [COMP_BITS-1:0] comp_y,
    input  logic signed [COMP_BITS-1:0] comp_z,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [UNIT_BITS-1:0] unit_x,
    output logic signed [UNIT_BITS-1:0] unit_y,
    output logic signed [UNIT_BITS-1:0] unit_z,
    output logic        [COMP_BITS-1:0] vec_length,
    output logic                        zero_vector
);

    logic en;

    // front stages
    logic       a_vld_reg;
    mag_t       a_mag_reg [3];
    logic [2:0] a_neg_reg;
    logic       b_vld_reg;
    sum_t       b_sq_reg  [3];
    logic [2:0] b_neg_reg;

    // digit stages
    logic       st_vld_reg  [NSTEPS+1];
    sum_t       st_sum_reg  [NSTEPS+1];
    logic [2:0] st_neg_reg  [NSTEPS+1];
    logic       st_zero_reg [NSTEPS+1];
    rem_t       st_rem_reg  [NSTEPS+1];
    root_t      st_root_reg [NSTEPS+1];
    err_t       st_e_reg    [NSTEPS+1][3];
    prod_t      st_ts_reg   [NSTEPS+1][3];
    quot_t      st_n_reg    [NSTEPS+1][3];

    // output register
    logic                        o_vld_reg;
    logic signed [UNIT_BITS-1:0] o_unit_reg [3];
    logic        [COMP_BITS-1:0] o_len_reg;
    logic                        o_zero_reg;

    logic signed [COMP_BITS-1:0] comp_in [3];
    sum_t                        sum_next;

    // Advance the whole pipe unless a finished result waits.
    assign en       = ~o_vld_reg | out_ready;
    assign in_ready = en;

    assign comp_in[0] = comp_x;
    assign comp_in[1] = comp_y;
    assign comp_in[2] = comp_z;

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            for (int i = 0; i <= NSTEPS; i++)
            begin
                st_vld_reg[i] <= 1'b0;
            end
            o_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg     <= in_valid;
            b_vld_reg     <= a_vld_reg;
            st_vld_reg[0] <= b_vld_reg;
            for (int i = 0; i < NSTEPS; i++)
            begin
                st_vld_reg[i+1] <= st_vld_reg[i];
            end
            o_vld_reg <= st_vld_reg[NSTEPS];
        end
    end

    // Take magnitudes and square them.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                a_neg_reg[c] <= comp_in[c][COMP_BITS-1];
                a_mag_reg[c] <= comp_in[c][COMP_BITS-1] ? (~comp_in[c] + 1'b1) : comp_in[c];
                b_sq_reg[c]  <= a_mag_reg[c] * a_mag_reg[c];
            end
            b_neg_reg <= a_neg_reg;
        end
    end

    assign sum_next = b_sq_reg[0] + b_sq_reg[1] + b_sq_reg[2];

    // Seed the digit stages: n = 0, T = -1.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_sum_reg[0]  <= sum_next;
            st_neg_reg[0]  <= b_neg_reg;
            st_zero_reg[0] <= (sum_next == '0);
            st_rem_reg[0]  <= '0;
            st_root_reg[0] <= '0;
            for (int c = 0; c < 3; c++)
            begin
                st_e_reg[0][c]  <= ($signed({{(E_W-SUM_W){1'b0}}, b_sq_reg[c]})
                                    <<< (2 * FRAC_BITS + 2))
                                   - $signed({{(E_W-SUM_W){1'b0}}, sum_next});
                st_ts_reg[0][c] <= -$signed({{(TS_W-SUM_W){1'b0}}, sum_next});
                st_n_reg[0][c]  <= '0;
            end
        end
    end

    // One root digit per stage; one quotient bit per component in stages up to FRAC_BITS.
    for (genvar gi = 0; gi < NSTEPS; gi++)
    begin : g_step
        sq_step_t sq;
        u_step_t  us [3];

        if (gi < COMP_BITS)
        begin : g_sq
            assign sq = sqrt_step(st_rem_reg[gi], st_root_reg[gi],
                                  st_sum_reg[gi][SUM_W-1-2*gi -: 2]);
        end
        else
        begin : g_sq_hold
            assign sq = '{rem: st_rem_reg[gi], root: st_root_reg[gi]};
        end

        for (genvar gc = 0; gc < 3; gc++)
        begin : g_comp
            if (gi <= FRAC_BITS)
            begin : g_u
                assign us[gc] = unit_step(st_e_reg[gi][gc], st_ts_reg[gi][gc],
                                          st_sum_reg[gi], FRAC_BITS - gi);
            end
            else
            begin : g_u_hold
                assign us[gc] = '{e: st_e_reg[gi][gc], ts: st_ts_reg[gi][gc], hit: 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_sum_reg[gi+1]  <= st_sum_reg[gi];
                st_neg_reg[gi+1]  <= st_neg_reg[gi];
                st_zero_reg[gi+1] <= st_zero_reg[gi];
                st_rem_reg[gi+1]  <= sq.rem;
                st_root_reg[gi+1] <= sq.root;
                for (int c = 0; c < 3; c++)
                begin
                    st_e_reg[gi+1][c]  <= us[c].e;
                    st_ts_reg[gi+1][c] <= us[c].ts;
                    if (gi <= FRAC_BITS)
                    begin
                        st_n_reg[gi+1][c] <= st_n_reg[gi][c]
                            | (quot_t'(us[c].hit) << (FRAC_BITS - gi));
                    end
                    else
                    begin
                        st_n_reg[gi+1][c] <= st_n_reg[gi][c];
                    end
                end
            end
        end
    end

    // Apply signs and drop results of a zero vector.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (st_zero_reg[NSTEPS])
                begin
                    o_unit_reg[c] <= '0;
                end
                else if (st_neg_reg[NSTEPS][c])
                begin
                    o_unit_reg[c] <= -$signed({1'b0, st_n_reg[NSTEPS][c]});
                end
                else
                begin
                    o_unit_reg[c] <= $signed({1'b0, st_n_reg[NSTEPS][c]});
                end
            end
            o_len_reg  <= st_root_reg[NSTEPS];
            o_zero_reg <= st_zero_reg[NSTEPS];
        end
    end

    assign out_valid   = o_vld_reg;
    assign unit_x      = o_unit_reg[0];
    assign unit_y      = o_unit_reg[1];
    assign unit_z      = o_unit_reg[2];
    assign vec_length  = o_len_reg;
    assign zero_vector = o_zero_reg;

endmodule

>>> hdl/v3n_checker.sv
// ----------------------------------------------------------------------------
// v3n_checker
// Port-level checks of the vector normalization unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "vec3_normalize_unit_assert.svh"

module v3n_checker
    import v3n_pkg::*;
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic signed [UNIT_BITS-1:0] unit_x,
    input logic signed [UNIT_BITS-1:0] unit_y,
    input logic signed [UNIT_BITS-1:0] unit_z,
    input logic        [COMP_BITS-1:0] vec_length,
    input logic                        zero_vector
);

    // zero flag and a zero length go together
    `V3N_CHECK_NOW(a_zero_len, out_valid, (zero_vector == 1'b1) == (vec_length == '0))

    // zero vector gives zero components
    `V3N_CHECK_NOW(a_zero_unit, out_valid && zero_vector,
                   unit_x == '0 && unit_y == '0 && unit_z == '0)

    // a stalled result holds
    `V3N_CHECK_NEXT(a_hold, out_valid && !out_ready,
                    out_valid && $stable(vec_length) && $stable(unit_x))

    // the pipe drains into the output, so a stall blocks input
    `V3N_CHECK_NOW(a_stall_in, out_valid && !out_ready, !in_ready)

endmodule

bind vec3_normalize_unit v3n_checker u_v3n_checker (.*);
